>>> hdl/fstd_pkg.sv
// Shared types and constants for the flow-serialized task dispatcher.
package fstd_pkg;

    localparam int KIND_W = 2;
    localparam int FLOW_W = 16;
    localparam int TASK_W = 16;
    localparam int REM_W  = 5;

    // Request kinds carried on s_tuser
    localparam logic [KIND_W-1:0] KIND_SUBMIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PURGE    = 2'd3;

    // Result word, accepted in the lowest bit
    typedef struct packed {
        logic [REM_W-1:0]  remaining;
        logic [TASK_W-1:0] grant_task;
        logic [FLOW_W-1:0] grant_flow;
        logic              granted;
        logic              accepted;
    } fstd_result_t;

    localparam int RESULT_W = $bits(fstd_result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Command from the sequencer to the busy-flow table
    typedef struct packed {
        logic              alloc;
        logic              clear;
        logic [FLOW_W-1:0] flow;
    } fstd_busy_cmd_t;

endpackage

>>> hdl/fstd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fstd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fstd_busy.sv
// Busy-flow table: one slot per worker, lookup, allocate and release.
module fstd_busy #(
    parameter int WORKERS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fstd_pkg::fstd_busy_cmd_t       cmd,
    input  logic [fstd_pkg::FLOW_W-1:0]    chk_flow,
    output logic                           chk_hit,
    output logic                           has_free
);

    logic [fstd_pkg::FLOW_W-1:0] flow_reg [WORKERS];
    logic [WORKERS-1:0]          valid_reg;
    logic [WORKERS-1:0]          free_oh;

    // First free slot (one-hot) and lookup of the checked flow
    always_comb begin
        logic seen;
        seen    = 1'b0;
        chk_hit = 1'b0;
        for (int w = 0; w < WORKERS; w++) begin
            free_oh[w] = !valid_reg[w] && !seen;
            seen       = seen || !valid_reg[w];
            chk_hit    = chk_hit || (valid_reg[w] && (flow_reg[w] == chk_flow));
        end
    end

    assign has_free = |(~valid_reg);

    // Slot valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int w = 0; w < WORKERS; w++) begin
                if (cmd.alloc && free_oh[w]) begin
                    valid_reg[w] <= 1'b1;
                end else if (cmd.clear && valid_reg[w] && (flow_reg[w] == cmd.flow)) begin
                    valid_reg[w] <= 1'b0;
                end
            end
        end
    end

    // Slot flow ids, meaningful only where valid
    always_ff @(posedge aclk) begin
        for (int w = 0; w < WORKERS; w++) begin
            if (cmd.alloc && free_oh[w]) begin
                flow_reg[w] <= cmd.flow;
            end
        end
    end

endmodule

>>> hdl/flow_serialized_task_dispatcher.sv
// Top level: ordered task queue in RAM with per-flow busy tracking.
// Submit, complete and dispatch with no free worker skip the scan and go to DONE.
// Dispatch with a free worker and purge scan all queued entries before DONE;
// the queue RAM's single read port scans and compacts one entry per cycle.
// One request at a time: s_tready is high only while idle, until DONE loads the result.
// Synchronous active-low reset clears count, busy marks and handshake; queue RAM is kept.
module flow_serialized_task_dispatcher #(
    parameter int QUEUE_DEPTH = 16,
    parameter int WORKERS     = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // flow_id[15:0], task_handle[31:16]
    input  logic [fstd_pkg::KIND_W-1:0]   s_tuser,  // kind[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accepted[0], granted[1], grant_flow[17:2], grant_task[33:18], remaining[38:34], zero[39]
    output logic [fstd_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = fstd_pkg::FLOW_W + fstd_pkg::TASK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [CW-1:0]                     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]                     wr_idx_reg, wr_idx_next;
    logic                              pend_reg, pend_next;
    logic                              found_reg, found_next;
    logic [fstd_pkg::KIND_W-1:0]       op_kind_reg, op_kind_next;
    logic [fstd_pkg::FLOW_W-1:0]       op_flow_reg, op_flow_next;
    fstd_pkg::fstd_result_t            res_reg, res_next;
    logic                              m_valid_reg, m_valid_next;
    fstd_pkg::fstd_result_t            m_res_reg, m_res_next;

    logic                              in_req;
    logic [fstd_pkg::KIND_W-1:0]       in_kind;
    logic [fstd_pkg::FLOW_W-1:0]       in_flow;
    logic [fstd_pkg::TASK_W-1:0]       in_task;

    logic                              ram_we, ram_re;
    logic [AW-1:0]                     ram_waddr, ram_raddr;
    logic [EW-1:0]                     ram_wdata, ram_rdata;
    logic [fstd_pkg::FLOW_W-1:0]       rd_flow;
    logic [fstd_pkg::TASK_W-1:0]       rd_task;
    logic                              drop;

    fstd_pkg::fstd_busy_cmd_t          busy_cmd;
    logic                              busy_hit, busy_has_free;

    assign in_req  = s_tvalid && s_tready;
    assign in_kind = s_tuser;
    assign in_flow = s_tdata[fstd_pkg::FLOW_W-1:0];
    assign in_task = s_tdata[EW-1:fstd_pkg::FLOW_W];
    assign rd_flow = ram_rdata[fstd_pkg::FLOW_W-1:0];
    assign rd_task = ram_rdata[EW-1:fstd_pkg::FLOW_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = fstd_pkg::M_DATA_W'(m_res_reg);

    // Queue storage: flow id in the low half, task handle in the high half
    fstd_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fstd_busy #(
        .WORKERS (WORKERS)
    ) u_busy (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (busy_cmd),
        .chk_flow (rd_flow),
        .chk_hit  (busy_hit),
        .has_free (busy_has_free)
    );

    // Entry dropped during the scan: purged flow, or the first eligible dispatch entry
    always_comb begin
        if (op_kind_reg == fstd_pkg::KIND_PURGE) begin
            drop = (rd_flow == op_flow_reg);
        end else begin
            drop = !found_reg && !busy_hit;
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        pend_next    = 1'b0;
        found_next   = found_reg;
        op_kind_next = op_kind_reg;
        op_flow_next = op_flow_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_idx_reg[AW-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = rd_idx_reg[AW-1:0];
        busy_cmd     = '0;

        // Output register drains independently of the sequencer
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    res_next     = '0;
                    op_kind_next = in_kind;
                    op_flow_next = in_flow;
                    rd_idx_next  = '0;
                    wr_idx_next  = '0;
                    found_next   = 1'b0;
                    state_next   = ST_DONE;
                    case (in_kind)
                        fstd_pkg::KIND_SUBMIT: begin
                            if (count_reg < CW'(QUEUE_DEPTH)) begin
                                ram_we            = 1'b1;
                                ram_waddr         = count_reg[AW-1:0];
                                ram_wdata         = {in_task, in_flow};
                                count_next        = count_reg + 1'b1;
                                res_next.accepted = 1'b1;
                            end
                        end
                        fstd_pkg::KIND_DISPATCH: begin
                            if (busy_has_free) begin
                                state_next = ST_SCAN;
                            end
                        end
                        fstd_pkg::KIND_COMPLETE: begin
                            busy_cmd.clear = 1'b1;
                            busy_cmd.flow  = in_flow;
                        end
                        default: begin
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle
                if (rd_idx_reg < count_reg) begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                // Compact the entry read last cycle
                if (pend_reg) begin
                    if (drop) begin
                        if (op_kind_reg == fstd_pkg::KIND_DISPATCH) begin
                            found_next          = 1'b1;
                            res_next.granted    = 1'b1;
                            res_next.grant_flow = rd_flow;
                            res_next.grant_task = rd_task;
                        end
                    end else begin
                        ram_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                end
                // Scan finished
                if (!(rd_idx_reg < count_reg) && !pend_reg) begin
                    count_next = wr_idx_reg;
                    if (op_kind_reg == fstd_pkg::KIND_PURGE) begin
                        res_next.remaining = fstd_pkg::REM_W'(wr_idx_reg);
                    end else if (found_reg) begin
                        busy_cmd.alloc = 1'b1;
                        busy_cmd.flow  = res_reg.grant_flow;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rd_idx_reg  <= rd_idx_next;
        wr_idx_reg  <= wr_idx_next;
        found_reg   <= found_next;
        op_kind_reg <= op_kind_next;
        op_flow_reg <= op_flow_next;
        res_reg     <= res_next;
        m_res_reg   <= m_res_next;
    end

endmodule

>>> hdl/fstd_checker.sv
// Port-level checker for the dispatcher and its bind statement.
module fstd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [31:0]                   s_tdata,
    input logic [fstd_pkg::KIND_W-1:0]   s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fstd_pkg::M_DATA_W-1:0] m_tdata
);

    // Held result stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One request in flight: input closes right after a request is taken
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // A result is never both a stored submit and a grant
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("accepted and granted both set");

    // A grant carries no purge count
    a_grant_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> (m_tdata[38:34] == 5'd0))
        else $error("grant with nonzero remaining");

endmodule

bind flow_serialized_task_dispatcher fstd_checker u_fstd_checker (.*);
